### rtl/mmenv_pkg.sv
// Shared types and constants for the min/max envelope decimator.
`timescale 1ns / 1ps

package mmenv_pkg;

  // Field widths of the sample and point formats.
  localparam int INDEX_BITS      = 24;
  localparam int VALUE_BITS      = 16;
  localparam int COL_BITS        = 13;
  localparam int SCALE_BITS      = 16;
  localparam int SCALE_FRAC_BITS = 16;
  localparam int OFFSET_BITS     = 24;
  localparam int MAX_COLUMNS     = 4096;

  // Configuration port geometry.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;

  // Register reset values.
  localparam logic [INDEX_BITS-1:0]  ORIGIN_RESET  = '0;
  localparam logic [SCALE_BITS-1:0]  SCALE_RESET   = SCALE_BITS'(32768);
  localparam logic [OFFSET_BITS-1:0] OFFSET_RESET  = '0;
  localparam logic [COL_BITS-1:0]    VISIBLE_RESET = COL_BITS'(4096);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ORIGIN  = 2'd0,
    REG_SCALE   = 2'd1,
    REG_OFFSET  = 2'd2,
    REG_VISIBLE = 2'd3
  } mmenv_reg_t;

  // Kind of an envelope point.
  typedef enum logic [1:0] {
    KIND_ENTER = 2'd0,
    KIND_MAX   = 2'd1,
    KIND_MIN   = 2'd2,
    KIND_EXIT  = 2'd3
  } mmenv_kind_t;

  // One input sample.
  typedef struct packed {
    logic [INDEX_BITS-1:0]        sample_index;
    logic signed [VALUE_BITS-1:0] sample_value;
    logic                         run_end;
  } mmenv_in_t;

  // One envelope point.
  typedef struct packed {
    logic [COL_BITS-1:0]          column;
    logic signed [VALUE_BITS-1:0] point_value;
    logic [1:0]                   point_kind;
    logic                         last_point;
  } mmenv_out_t;

  // A sample after its index has been mapped to a column.
  typedef struct packed {
    logic [COL_BITS-1:0]          column;
    logic signed [VALUE_BITS-1:0] value;
    logic                         run_end;
  } mmenv_col_t;

  // One closed column, ready to be sent as four points.
  typedef struct packed {
    logic [COL_BITS-1:0]          column;
    logic signed [VALUE_BITS-1:0] enter_val;
    logic signed [VALUE_BITS-1:0] hi_val;
    logic signed [VALUE_BITS-1:0] lo_val;
    logic signed [VALUE_BITS-1:0] exit_val;
  } mmenv_bar_t;

endpackage

### rtl/minmax_envelope_decimator_core.sv
// Top level of the min/max envelope decimator with its configuration registers.
//
// Samples enter on in_valid/in_ready, one per cycle unless stalled. Each
// sample index is mapped to a display column in a three-stage pipeline (index
// difference and scale multiply, offset and clamp), then the column tracker
// updates the open column's enter, exit, minimum and maximum values.
// A change of column or a sample marked run_end loads a burst of four points
// (enter, max, min, exit) into the burst buffer; both together give eight.
// Points leave on out_valid/out_ready, one per transfer, with last_point on
// the final point of the burst.
// The first point of a burst is valid once the sample that causes it has passed
// the s1, s2 and s3 registers and been taken by the tracker. Samples that close
// no column are taken every cycle; a sample that closes a column waits until the
// previous burst's last point transfers.
// A stalled receiver holds the current point; samples keep flowing until a
// new burst is needed and the three pipeline registers fill.
// Reset clears the pipeline, the burst buffer and the open column, and loads
// the register defaults. Registers are written through cfg_write/cfg_index/
// cfg_data, by the user only while the block is idle; the block does not check.
`timescale 1ns / 1ps

module minmax_envelope_decimator_core
  import mmenv_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mmenv_in_t                 in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mmenv_out_t                out_data,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // Configuration registers.
  logic [INDEX_BITS-1:0]  origin_sample;
  logic [SCALE_BITS-1:0]  pixels_per_sample;
  logic [OFFSET_BITS-1:0] left_pixel_offset;
  logic [COL_BITS-1:0]    visible_pixels;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_sample     <= ORIGIN_RESET;
      pixels_per_sample <= SCALE_RESET;
      left_pixel_offset <= OFFSET_RESET;
      visible_pixels    <= VISIBLE_RESET;
    end else if (cfg_write) begin
      unique case (mmenv_reg_t'(cfg_index))
        REG_ORIGIN:  origin_sample     <= cfg_data[INDEX_BITS-1:0];
        REG_SCALE:   pixels_per_sample <= cfg_data[SCALE_BITS-1:0];
        REG_OFFSET:  left_pixel_offset <= cfg_data[OFFSET_BITS-1:0];
        REG_VISIBLE: visible_pixels    <= cfg_data[COL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Mapped samples between the column pipeline and the tracker.
  logic       col_valid;
  logic       col_ready;
  mmenv_col_t col_data;

  mmenv_map u_map (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .origin_sample     (origin_sample),
    .pixels_per_sample (pixels_per_sample),
    .left_pixel_offset (left_pixel_offset),
    .visible_pixels    (visible_pixels),
    .col_valid         (col_valid),
    .col_ready         (col_ready),
    .col_data          (col_data)
  );

  mmenv_track u_track (
    .clk       (clk),
    .rst       (rst),
    .col_valid (col_valid),
    .col_ready (col_ready),
    .col_data  (col_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/mmenv_map.sv
// Three-stage pipeline that maps a sample index to a display column.
`timescale 1ns / 1ps

module mmenv_map
  import mmenv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mmenv_in_t              in_data,
  input  logic [INDEX_BITS-1:0]  origin_sample,
  input  logic [SCALE_BITS-1:0]  pixels_per_sample,
  input  logic [OFFSET_BITS-1:0] left_pixel_offset,
  input  logic [COL_BITS-1:0]    visible_pixels,
  output logic                   col_valid,
  input  logic                   col_ready,
  output mmenv_col_t             col_data
);

  localparam int PROD_BITS = INDEX_BITS + SCALE_BITS;

  // Stage registers.
  logic                         s1_valid;
  mmenv_in_t                    s1;
  logic                         s2_valid;
  logic [INDEX_BITS-1:0]        s2_raw;
  logic                         s2_below;
  logic signed [VALUE_BITS-1:0] s2_value;
  logic                         s2_end;
  logic                         s3_valid;
  mmenv_col_t                   s3;

  // Stage load enables, each stage moves when the one after it has room.
  logic s3_load;
  logic s2_load;
  logic s1_load;

  assign s3_load  = !s3_valid || col_ready;
  assign s2_load  = !s2_valid || s3_load;
  assign s1_load  = !s1_valid || s2_load;
  assign in_ready = s1_load;

  // Distance from the origin and the scaled column.
  logic [INDEX_BITS:0]   diff;
  logic [PROD_BITS-1:0]  prod;

  assign diff = {1'b0, s1.sample_index} - {1'b0, origin_sample};
  assign prod = diff[INDEX_BITS-1:0] * pixels_per_sample;

  // Offset subtraction and clamp to the visible width.
  logic [INDEX_BITS:0]   shifted;
  logic [COL_BITS-1:0]   limit;
  logic [COL_BITS-1:0]   col_clamped;

  assign shifted = {1'b0, s2_raw} - {{(INDEX_BITS + 1 - OFFSET_BITS){1'b0}}, left_pixel_offset};
  assign limit   = (visible_pixels > COL_BITS'(MAX_COLUMNS)) ? COL_BITS'(MAX_COLUMNS)
                                                             : visible_pixels;

  always_comb begin
    if (s2_below || shifted[INDEX_BITS]) begin
      col_clamped = '0;
    end else if (shifted[INDEX_BITS-1:0] > {{(INDEX_BITS - COL_BITS){1'b0}}, limit}) begin
      col_clamped = limit;
    end else begin
      col_clamped = shifted[COL_BITS-1:0];
    end
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_load) s1_valid <= in_valid;
      if (s2_load) s2_valid <= s1_valid;
      if (s3_load) s3_valid <= s2_valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1 <= in_data;
    end
    if (s2_load) begin
      s2_raw   <= prod[SCALE_FRAC_BITS +: INDEX_BITS];
      s2_below <= diff[INDEX_BITS];
      s2_value <= s1.sample_value;
      s2_end   <= s1.run_end;
    end
    if (s3_load) begin
      s3.column  <= col_clamped;
      s3.value   <= s2_value;
      s3.run_end <= s2_end;
    end
  end

  assign col_valid = s3_valid;
  assign col_data  = s3;

endmodule

### rtl/mmenv_track.sv
// Column tracker: keeps the open column's statistics and sends point bursts.
`timescale 1ns / 1ps

module mmenv_track
  import mmenv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       col_valid,
  output logic       col_ready,
  input  mmenv_col_t col_data,
  output logic       out_valid,
  input  logic       out_ready,
  output mmenv_out_t out_data
);

  // Open column state.
  logic [COL_BITS-1:0]          open_column;
  logic                         column_open;
  logic signed [VALUE_BITS-1:0] enter_val;
  logic signed [VALUE_BITS-1:0] exit_val;
  logic signed [VALUE_BITS-1:0] min_val;
  logic signed [VALUE_BITS-1:0] max_val;
  logic signed [VALUE_BITS-1:0] prev_min_val;
  logic signed [VALUE_BITS-1:0] prev_max_val;
  logic                         have_prev;

  // Burst buffer: up to two bars, walked one point per transfer.
  mmenv_bar_t bar [2];
  logic [1:0] bar_count;
  logic [2:0] ptr;

  logic signed [VALUE_BITS-1:0] v;
  assign v = col_data.value;

  // A change of column closes the open bar.
  logic close_a;
  logic emits;
  assign close_a = column_open && (col_data.column != open_column);
  assign emits   = close_a || col_data.run_end;

  // Continuity clamp for the bar being closed.
  logic signed [VALUE_BITS-1:0] lo_a;
  logic signed [VALUE_BITS-1:0] hi_a;

  always_comb begin
    lo_a = min_val;
    hi_a = max_val;
    if (have_prev) begin
      if (min_val > prev_max_val) begin
        lo_a = prev_max_val;
      end else if (max_val < prev_min_val) begin
        hi_a = prev_min_val;
      end
    end
  end

  // Statistics of the column after this sample.
  logic [COL_BITS-1:0]          col_next;
  logic signed [VALUE_BITS-1:0] enter_next;
  logic signed [VALUE_BITS-1:0] min_next;
  logic signed [VALUE_BITS-1:0] max_next;

  always_comb begin
    if (close_a || !column_open) begin
      col_next   = col_data.column;
      enter_next = v;
      min_next   = v;
      max_next   = v;
    end else begin
      col_next   = open_column;
      enter_next = enter_val;
      min_next   = (v < min_val) ? v : min_val;
      max_next   = (v > max_val) ? v : max_val;
    end
  end

  // Previous bar as seen by the run-end bar.
  logic                         pv_have;
  logic signed [VALUE_BITS-1:0] pv_min;
  logic signed [VALUE_BITS-1:0] pv_max;

  assign pv_have = close_a || have_prev;
  assign pv_min  = close_a ? lo_a : prev_min_val;
  assign pv_max  = close_a ? hi_a : prev_max_val;

  // Continuity clamp for the bar closed by the end of the run.
  logic signed [VALUE_BITS-1:0] lo_b;
  logic signed [VALUE_BITS-1:0] hi_b;

  always_comb begin
    lo_b = min_next;
    hi_b = max_next;
    if (pv_have) begin
      if (min_next > pv_max) begin
        lo_b = pv_max;
      end else if (max_next < pv_min) begin
        hi_b = pv_min;
      end
    end
  end

  // Bars to load into the burst buffer.
  mmenv_bar_t bar_a;
  mmenv_bar_t bar_b;

  always_comb begin
    bar_a.column    = open_column;
    bar_a.enter_val = enter_val;
    bar_a.hi_val    = hi_a;
    bar_a.lo_val    = lo_a;
    bar_a.exit_val  = exit_val;
    bar_b.column    = col_next;
    bar_b.enter_val = enter_next;
    bar_b.hi_val    = hi_b;
    bar_b.lo_val    = lo_b;
    bar_b.exit_val  = v;
  end

  // Output side of the burst buffer.
  logic       last;
  logic       out_xfer;
  logic       buf_free;
  logic       take;
  mmenv_bar_t cur;

  assign cur       = bar[ptr[2]];
  assign last      = (ptr[1:0] == KIND_EXIT) && ({1'b0, ptr[2]} == bar_count - 2'd1);
  assign out_valid = (bar_count != 2'd0);
  assign out_xfer  = out_valid && out_ready;
  assign buf_free  = !out_valid || (out_xfer && last);
  assign col_ready = !emits || buf_free;
  assign take      = col_valid && col_ready;

  always_comb begin
    out_data.column     = cur.column;
    out_data.point_kind = ptr[1:0];
    out_data.last_point = last;
    case (mmenv_kind_t'(ptr[1:0]))
      KIND_ENTER: out_data.point_value = cur.enter_val;
      KIND_MAX:   out_data.point_value = cur.hi_val;
      KIND_MIN:   out_data.point_value = cur.lo_val;
      default:    out_data.point_value = cur.exit_val;
    endcase
  end

  // Column state update on each sample transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      open_column  <= '0;
      column_open  <= 1'b0;
      enter_val    <= '0;
      exit_val     <= '0;
      min_val      <= '0;
      max_val      <= '0;
      prev_min_val <= '0;
      prev_max_val <= '0;
      have_prev    <= 1'b0;
    end else if (take) begin
      open_column <= col_next;
      enter_val   <= enter_next;
      exit_val    <= v;
      min_val     <= min_next;
      max_val     <= max_next;
      if (col_data.run_end) begin
        column_open  <= 1'b0;
        have_prev    <= 1'b0;
        prev_min_val <= lo_b;
        prev_max_val <= hi_b;
      end else begin
        column_open  <= 1'b1;
        have_prev    <= pv_have;
        prev_min_val <= pv_min;
        prev_max_val <= pv_max;
      end
    end
  end

  // Burst buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      bar_count <= 2'd0;
      ptr       <= '0;
    end else if (take && emits) begin
      bar_count <= (close_a && col_data.run_end) ? 2'd2 : 2'd1;
      ptr       <= '0;
    end else if (out_xfer) begin
      if (last) begin
        bar_count <= 2'd0;
      end
      ptr <= ptr + 3'd1;
    end
  end

  // Burst buffer payload.
  always_ff @(posedge clk) begin
    if (take && emits) begin
      bar[0] <= close_a ? bar_a : bar_b;
      bar[1] <= bar_b;
    end
  end

endmodule

### sim/tb_minmax_envelope_decimator_core.sv
// Self-checking testbench for the min/max envelope decimator core.
`timescale 1ns / 1ps

module tb_minmax_envelope_decimator_core;
  import mmenv_pkg::*;

  localparam int SETTLE_CYCLES = 10;
  localparam int QUIET_LIMIT   = 5000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  mmenv_in_t                 in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  mmenv_out_t                out_data;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // Samples waiting for the driver and points the block still owes us.
  mmenv_in_t  samples_pending[$];
  mmenv_out_t points_due[$];
  int unsigned mismatch_count = 0;

  // Idle controls for both channels, changed between phases.
  bit          in_idle_on  = 1'b1;
  bit          out_idle_on = 1'b1;
  int unsigned in_gap      = 0;
  int unsigned out_stall   = 0;
  int unsigned quiet_cycles = 0;

  // Shadow copy of the view registers.
  logic [INDEX_BITS-1:0]  cfg_origin  = ORIGIN_RESET;
  logic [SCALE_BITS-1:0]  cfg_scale   = SCALE_RESET;
  logic [OFFSET_BITS-1:0] cfg_offset  = OFFSET_RESET;
  logic [COL_BITS-1:0]    cfg_visible = VISIBLE_RESET;

  // Envelope state of the open column and of the previous bar.
  logic [COL_BITS-1:0]          bar_column = '0;
  bit                           bar_open   = 1'b0;
  logic signed [VALUE_BITS-1:0] bar_enter  = '0;
  logic signed [VALUE_BITS-1:0] bar_exit   = '0;
  logic signed [VALUE_BITS-1:0] bar_min    = '0;
  logic signed [VALUE_BITS-1:0] bar_max    = '0;
  logic signed [VALUE_BITS-1:0] prev_min   = '0;
  logic signed [VALUE_BITS-1:0] prev_max   = '0;
  bit                           have_prev  = 1'b0;

  minmax_envelope_decimator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 30);
  endfunction

  // Screen column of a sample index under the current view.
  function automatic logic [COL_BITS-1:0] column_of(logic [INDEX_BITS-1:0] idx);
    longint diff;
    longint col;
    longint lim;
    diff = longint'(idx) - longint'(cfg_origin);
    lim  = (cfg_visible > MAX_COLUMNS) ? longint'(MAX_COLUMNS) : longint'(cfg_visible);
    if (diff < 0) begin
      return '0;
    end
    col = (diff * longint'(cfg_scale)) >>> SCALE_FRAC_BITS;
    col = col - longint'(cfg_offset);
    if (col < 0) begin
      col = 0;
    end
    if (col > lim) begin
      col = lim;
    end
    return COL_BITS'(col);
  endfunction

  // Close the open column: apply the continuity clamp and queue four points.
  task automatic close_bar(bit ends_burst);
    logic signed [VALUE_BITS-1:0] lo;
    logic signed [VALUE_BITS-1:0] hi;
    mmenv_out_t pt;
    lo = bar_min;
    hi = bar_max;
    if (have_prev) begin
      if (lo > prev_max) begin
        lo = prev_max;
      end else if (hi < prev_min) begin
        hi = prev_min;
      end
    end
    pt.column = bar_column;
    pt.last_point = 1'b0;
    pt.point_value = bar_enter;
    pt.point_kind  = KIND_ENTER;
    points_due.push_back(pt);
    pt.point_value = hi;
    pt.point_kind  = KIND_MAX;
    points_due.push_back(pt);
    pt.point_value = lo;
    pt.point_kind  = KIND_MIN;
    points_due.push_back(pt);
    pt.point_value = bar_exit;
    pt.point_kind  = KIND_EXIT;
    pt.last_point  = ends_burst;
    points_due.push_back(pt);
    prev_min  = lo;
    prev_max  = hi;
    have_prev = 1'b1;
  endtask

  task automatic open_bar(logic [COL_BITS-1:0] col, logic signed [VALUE_BITS-1:0] v);
    bar_column = col;
    bar_open   = 1'b1;
    bar_enter  = v;
    bar_exit   = v;
    bar_min    = v;
    bar_max    = v;
  endtask

  // Envelope tracking for one accepted sample.
  task automatic track_sample(mmenv_in_t s);
    logic [COL_BITS-1:0]          col;
    logic signed [VALUE_BITS-1:0] v;
    col = column_of(s.sample_index);
    v   = s.sample_value;
    if (bar_open && col != bar_column) begin
      close_bar(!s.run_end);
      open_bar(col, v);
    end else if (bar_open) begin
      if (v < bar_min) begin
        bar_min = v;
      end
      if (v > bar_max) begin
        bar_max = v;
      end
      bar_exit = v;
    end else begin
      open_bar(col, v);
    end
    if (s.run_end) begin
      close_bar(1'b1);
      bar_open  = 1'b0;
      have_prev = 1'b0;
    end
  endtask

  // Input driver: holds each sample until its transfer, then inserts a gap.
  always @(posedge clk) begin : drive_samples
    logic      valid_next;
    mmenv_in_t data_next;
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_gap = 0;
    end else begin
      valid_next = in_valid;
      data_next  = in_data;
      if (in_valid && in_ready) begin
        track_sample(in_data);
        valid_next = 1'b0;
      end
      if (!valid_next) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (samples_pending.size() > 0) begin
          data_next  = samples_pending.pop_front();
          valid_next = 1'b1;
          in_gap = in_idle_on ? pick_gap() : 0;
        end
      end
      in_valid <= valid_next;
      in_data  <= data_next;
    end
  end

  // Output monitor: checks each point transfer and stalls the receiver at random.
  always @(posedge clk) begin : check_points
    mmenv_out_t want;
    logic       ready_next;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (points_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected point: col %0d val %0d kind %0d last %0d", $time,
                   out_data.column, $signed(out_data.point_value), out_data.point_kind,
                   out_data.last_point);
        end else begin
          want = points_due.pop_front();
          if (out_data.column !== want.column || out_data.point_value !== want.point_value ||
              out_data.point_kind !== want.point_kind ||
              out_data.last_point !== want.last_point) begin
            mismatch_count++;
            $display("%0t: point mismatch: expected col %0d val %0d kind %0d last %0d,",
                     $time, want.column, $signed(want.point_value), want.point_kind,
                     want.last_point,
                     " got col %0d val %0d kind %0d last %0d",
                     out_data.column, $signed(out_data.point_value),
                     out_data.point_kind, out_data.last_point);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
        if (out_idle_on && $urandom_range(0, 3) == 0) begin
          out_stall = pick_gap();
        end
      end
      out_ready <= ready_next;
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("** minmax_envelope_decimator_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic add_sample(logic [INDEX_BITS-1:0] idx, int v, bit last);
    mmenv_in_t s;
    s.sample_index = idx;
    s.sample_value = VALUE_BITS'(v);
    s.run_end      = last;
    samples_pending.push_back(s);
  endtask

  // Wait until every sample is in and every point is out, then let the pipeline drain.
  task automatic settle();
    do begin
      @(negedge clk);
    end while (samples_pending.size() != 0 || in_valid || points_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(mmenv_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_ORIGIN:  cfg_origin  = value[INDEX_BITS-1:0];
      REG_SCALE:   cfg_scale   = value[SCALE_BITS-1:0];
      REG_OFFSET:  cfg_offset  = value[OFFSET_BITS-1:0];
      REG_VISIBLE: cfg_visible = value[COL_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Program a full view; the upper data bits of the narrow registers carry noise.
  task automatic set_view(int unsigned origin, int unsigned scale, int unsigned offset,
                          int unsigned visible);
    write_reg(REG_ORIGIN, CFG_DATA_BITS'(origin));
    write_reg(REG_SCALE, {8'($urandom), 16'(scale)});
    write_reg(REG_OFFSET, CFG_DATA_BITS'(offset));
    write_reg(REG_VISIBLE, {11'($urandom), 13'(visible)});
    in_idle_on  = ($urandom_range(0, 3) != 0);
    out_idle_on = ($urandom_range(0, 3) != 0);
  endtask

  // Mostly rising runs that land in the visible window, with some random noise.
  task automatic queue_random(int unsigned count);
    int unsigned left;
    int unsigned run_len;
    int unsigned step_max;
    longint      idx;
    int          v;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 7) == 0) begin
        add_sample(INDEX_BITS'($urandom), int'($urandom), $urandom_range(0, 3) == 0);
        left--;
      end else begin
        run_len  = $urandom_range(1, 12);
        step_max = 65536 / cfg_scale;
        idx = longint'(cfg_origin) + (longint'(cfg_offset) +
              longint'($urandom_range(0, cfg_visible))) * 65536 / longint'(cfg_scale);
        if ($urandom_range(0, 5) == 0) begin
          idx = idx - longint'($urandom_range(1, 50));
        end
        v = int'($urandom_range(0, 65535)) - 32768;
        for (int i = 0; i < run_len && left > 0; i++) begin
          add_sample(INDEX_BITS'(idx), v, i == run_len - 1);
          left--;
          idx = idx + longint'($urandom_range(0, step_max));
          if ($urandom_range(0, 7) == 0) begin
            v = int'($urandom_range(0, 65535)) - 32768;
          end else begin
            v = v + int'($urandom_range(0, 4000)) - 2000;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
          end
        end
      end
    end
  endtask

  // Test sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset view, half a pixel per sample: clamp up and down, value extremes,
    // run end alone and together with a column change, clamped index, index going back.
    @(negedge clk);
    add_sample(0, 0, 0);
    add_sample(1, 10, 0);
    add_sample(2, 50, 0);
    add_sample(3, 60, 0);
    add_sample(4, -100, 0);
    add_sample(5, -90, 0);
    add_sample(6, 32767, 0);
    add_sample(7, -32768, 0);
    add_sample(8, 5, 1);
    add_sample(20, 7, 1);
    add_sample(24'hFFFFFF, -1, 0);
    add_sample(24'hFFFFFE, 1, 0);
    add_sample(10, 3, 0);
    add_sample(24'hFFFFFF, 4, 1);
    add_sample(100, 1, 0);
    add_sample(40, 2, 0);
    add_sample(100, 3, 1);
    settle();

    set_view(0, 65535, 0, 4096);
    @(negedge clk);
    queue_random(28);
    settle();

    // Everything lies below the origin or left of the clip.
    set_view(24'hFFFFFF, 1, 24'hFFFFFF, 1);
    @(negedge clk);
    add_sample(0, -32768, 0);
    add_sample(24'hFFFFFF, 32767, 1);
    queue_random(20);
    settle();

    set_view(1000, 4096, 10, 100);
    @(negedge clk);
    queue_random(28);
    settle();

    // Visible width beyond the column limit.
    set_view(500, 20000, 0, 8191);
    @(negedge clk);
    queue_random(28);
    settle();

    // Zero visible width folds every sample into column zero.
    set_view(0, 40000, 0, 0);
    @(negedge clk);
    queue_random(20);
    settle();

    set_view($urandom_range(0, 5000), $urandom_range(1, 65535), $urandom_range(0, 200),
             $urandom_range(1, 4096));
    @(negedge clk);
    queue_random(28);
    settle();

    set_view(0, 32768, 0, 4096);
    @(negedge clk);
    queue_random(25);
    settle();

    if (mismatch_count == 0 && points_due.size() == 0) begin
      $display("** minmax_envelope_decimator_core: PASSED **");
    end else begin
      $display("** minmax_envelope_decimator_core: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mmenv_pkg.sv
rtl/mmenv_map.sv
rtl/mmenv_track.sv
rtl/minmax_envelope_decimator_core.sv
sim/tb_minmax_envelope_decimator_core.sv
